FILE: design/bounded_array_list_engine_top_macros.svh
// Assertion macros shared by the list engine modules.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define BAL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BAL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAL_ASSERT_IMP(lbl, ante, cons, msg)
`define BAL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/bal_pkg.sv
// Types and codes shared by the list engine modules.
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

    localparam int AMT_W = 16;

    // operation codes
    localparam logic [3:0] FUNC_INS_FRONT = 4'd0;
    localparam logic [3:0] FUNC_INS_BACK  = 4'd1;
    localparam logic [3:0] FUNC_INS_AT    = 4'd2;
    localparam logic [3:0] FUNC_DEL_FRONT = 4'd3;
    localparam logic [3:0] FUNC_DEL_BACK  = 4'd4;
    localparam logic [3:0] FUNC_DEL_AT    = 4'd5;
    localparam logic [3:0] FUNC_SEARCH    = 4'd6;
    localparam logic [3:0] FUNC_ROTATE    = 4'd7;
    localparam logic [3:0] FUNC_DUMP      = 4'd8;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] value;
        logic [3:0]         position;
        logic [AMT_W-1:0]   amount;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         index;
        logic signed [31:0] data;
        logic [3:0]         count;
        logic               last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       d_clr;
        logic       step;
        logic       copy;
        logic       commit;
        logic       rem_start;
        logic       set_res;
        logic [2:0] res_status;
        logic       res_hit;
        logic       out_res;
        logic       out_dump;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] func;
        logic       full;
        logic       empty;
        logic       pos_bad;
        logic       copy_done;
        logic       scan_done;
        logic       hit;
        logic       pend;
        logic       out_busy;
        logic       rem_done;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/bal_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_array_list_engine_top_macros.svh"

module bal_rem #(
    parameter int DIV_W = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bal_pkg::AMT_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]          divisor,
    output logic                           done,
    output logic [DIV_W-1:0]               rem
);

    localparam int SW = $clog2(bal_pkg::AMT_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [SW-1:0]             step_reg, step_next;
    logic [bal_pkg::AMT_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0]          div_reg, div_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [DIV_W:0]            trial;
    logic [DIV_W:0]            trial_sub;

    always_comb
    begin
        trial     = {rem_reg, num_reg[bal_pkg::AMT_W-1]};
        trial_sub = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = trial_sub[DIV_W-1:0];
            num_next  = {num_reg[bal_pkg::AMT_W-2:0], 1'b0};
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(bal_pkg::AMT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `BAL_ASSERT_IMP(a_rem_below_div, done_reg, rem_reg < div_reg, "remainder not below divisor")

endmodule

`default_nettype wire

FILE: design/bal_dp.sv
// Datapath: item register, two-bank element memory, scan counter, result register.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_array_list_engine_top_macros.svh"

module bal_dp #(
    parameter int CAPACITY = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bal_pkg::in_item_t  op_item,
    input  wire bal_pkg::dp_cmd_t   cmd,
    output bal_pkg::dp_stat_t       stat,
    input  wire logic               res_stall,
    output logic                    res_valid,
    output bal_pkg::out_item_t      res_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int MD = 2 * (2 ** IW);

    bal_pkg::in_item_t  item_reg, item_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      d_reg, d_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;
    logic               wr_pend_reg, wr_pend_next;
    logic               wr_val_reg, wr_val_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [2:0]         res_idx_reg, res_idx_next;
    logic               res_valid_reg, res_valid_next;
    bal_pkg::out_item_t res_item_reg, res_item_next;
    logic [31:0]        rdata_reg;

    logic [31:0] mem [MD];

    logic [3:0]    func;
    logic          is_ins, is_del;
    logic [CW+3:0] cnt_ext, pos_ext;
    logic          pos_bad;
    logic [CW-1:0] p_eff, new_cnt, src, rot_amt;
    logic [CW:0]   rot_sum, rot_wrap;
    logic          use_val;
    logic [IW:0]   rd_addr, wr_addr;
    logic [31:0]   wdata;
    logic [CW+2:0] idx_ext;
    logic [2:0]    idx3;
    logic [3:0]    cnt4;
    logic          rem_done;

    assign func   = item_reg.func;
    assign is_ins = (func == bal_pkg::FUNC_INS_FRONT) || (func == bal_pkg::FUNC_INS_BACK)
                 || (func == bal_pkg::FUNC_INS_AT);
    assign is_del = (func == bal_pkg::FUNC_DEL_FRONT) || (func == bal_pkg::FUNC_DEL_BACK)
                 || (func == bal_pkg::FUNC_DEL_AT);

    assign cnt_ext = {4'b0000, cnt_reg};
    assign pos_ext = {{CW{1'b0}}, item_reg.position};
    assign pos_bad = ((func == bal_pkg::FUNC_INS_AT) && (pos_ext > cnt_ext))
                  || ((func == bal_pkg::FUNC_DEL_AT) && (pos_ext >= cnt_ext));

    always_comb
    begin
        case (func)
            bal_pkg::FUNC_INS_BACK: p_eff = cnt_reg;
            bal_pkg::FUNC_DEL_BACK: p_eff = cnt_reg - CW'(1);
            bal_pkg::FUNC_INS_AT:   p_eff = pos_ext[CW-1:0];
            bal_pkg::FUNC_DEL_AT:   p_eff = pos_ext[CW-1:0];
            default:                p_eff = '0;
        endcase
    end

    assign new_cnt = is_ins ? cnt_reg + CW'(1) : (is_del ? cnt_reg - CW'(1) : cnt_reg);

    // rotate source: d + s, wrapped once at the count
    assign rot_sum  = {1'b0, d_reg} + {1'b0, rot_amt};
    assign rot_wrap = (rot_sum >= {1'b0, cnt_reg}) ? rot_sum - {1'b0, cnt_reg} : rot_sum;

    always_comb
    begin
        if (is_ins)
            src = (d_reg < p_eff) ? d_reg : d_reg - CW'(1);
        else if (is_del)
            src = (d_reg < p_eff) ? d_reg : d_reg + CW'(1);
        else
            src = rot_wrap[CW-1:0];
    end

    assign use_val = is_ins && (d_reg == p_eff);
    assign rd_addr = {bank_reg, cmd.copy ? src[IW-1:0] : d_reg[IW-1:0]};
    assign wr_addr = {~bank_reg, rd_idx_reg[IW-1:0]};
    assign wdata   = wr_val_reg ? $unsigned(item_reg.value) : rdata_reg;

    assign idx_ext = {3'b000, rd_idx_reg};
    assign idx3    = idx_ext[2:0];
    assign cnt4    = cnt_ext[3:0];

    always_comb
    begin
        item_next       = cmd.capture ? op_item : item_reg;
        d_next          = cmd.d_clr ? '0 : (cmd.step ? d_reg + CW'(1) : d_reg);
        rd_idx_next     = cmd.step ? d_reg : rd_idx_reg;
        pend_next       = cmd.step;
        wr_pend_next    = cmd.step && cmd.copy;
        wr_val_next     = use_val;
        cnt_next        = cmd.commit ? new_cnt : cnt_reg;
        bank_next       = cmd.commit ? ~bank_reg : bank_reg;
        res_status_next = cmd.set_res ? cmd.res_status : res_status_reg;
        res_idx_next    = res_idx_reg;
        if (cmd.set_res)
            res_idx_next = cmd.res_hit ? idx3 : 3'd0;

        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        if (cmd.out_res)
        begin
            res_valid_next       = 1'b1;
            res_item_next.status = res_status_reg;
            res_item_next.index  = res_idx_reg;
            res_item_next.data   = '0;
            res_item_next.count  = cnt4;
            res_item_next.last   = 1'b1;
        end
        else if (cmd.out_dump)
        begin
            res_valid_next       = 1'b1;
            res_item_next.status = bal_pkg::ST_OK;
            res_item_next.index  = idx3;
            res_item_next.data   = $signed(rdata_reg);
            res_item_next.count  = cnt4;
            res_item_next.last   = (d_reg == cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            bank_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            wr_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            bank_reg      <= bank_next;
            pend_reg      <= pend_next;
            wr_pend_reg   <= wr_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        d_reg          <= d_next;
        rd_idx_reg     <= rd_idx_next;
        wr_val_reg     <= wr_val_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_item_reg   <= res_item_next;
    end

    // element memory: read active bank, write the other one
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            mem[wr_addr] <= wdata;
        if (cmd.step)
            rdata_reg <= mem[rd_addr];
    end

    bal_rem #(
        .DIV_W (CW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (item_reg.amount),
        .divisor  (cnt_reg),
        .done     (rem_done),
        .rem      (rot_amt)
    );

    always_comb
    begin
        stat.func      = func;
        stat.full      = (cnt_reg == CW'(CAPACITY));
        stat.empty     = (cnt_reg == '0);
        stat.pos_bad   = pos_bad;
        stat.copy_done = (d_reg == new_cnt);
        stat.scan_done = (d_reg == cnt_reg);
        stat.hit       = pend_reg && (rdata_reg == $unsigned(item_reg.value));
        stat.pend      = pend_reg;
        stat.out_busy  = res_valid_reg && res_stall;
        stat.rem_done  = rem_done;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `BAL_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CW'(CAPACITY), "count above capacity")
    `BAL_ASSERT_IMP(a_load_free, cmd.out_res || cmd.out_dump, !stat.out_busy, "result clobbered")
    `BAL_ASSERT_NXT(a_commit_flip, cmd.commit, bank_reg != $past(bank_reg), "banks not swapped")

endmodule

`default_nettype wire

FILE: design/bal_ctrl.sv
// Controller: sequences decode, remainder wait, copy, search, dump and result steps.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_array_list_engine_top_macros.svh"

module bal_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              op_valid,
    output logic                   op_stall,
    input  wire bal_pkg::dp_stat_t stat,
    output bal_pkg::dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_MOD      = 3'd2;
    localparam logic [2:0] S_COPY     = 3'd3;
    localparam logic [2:0] S_SEARCH   = 3'd4;
    localparam logic [2:0] S_DUMP_RD  = 3'd5;
    localparam logic [2:0] S_DUMP_OUT = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.d_clr = 1'b1;
                case (stat.func)
                    bal_pkg::FUNC_INS_FRONT, bal_pkg::FUNC_INS_BACK, bal_pkg::FUNC_INS_AT:
                    begin
                        cmd.set_res = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res_status = bal_pkg::ST_FULL;
                            state_next     = S_RESULT;
                        end
                        else if (stat.pos_bad)
                        begin
                            cmd.res_status = bal_pkg::ST_BADPOS;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            cmd.res_status = bal_pkg::ST_OK;
                            state_next     = S_COPY;
                        end
                    end
                    bal_pkg::FUNC_DEL_FRONT, bal_pkg::FUNC_DEL_BACK, bal_pkg::FUNC_DEL_AT:
                    begin
                        cmd.set_res = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.res_status = bal_pkg::ST_EMPTY;
                            state_next     = S_RESULT;
                        end
                        else if (stat.pos_bad)
                        begin
                            cmd.res_status = bal_pkg::ST_BADPOS;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            cmd.res_status = bal_pkg::ST_OK;
                            state_next     = S_COPY;
                        end
                    end
                    bal_pkg::FUNC_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = bal_pkg::ST_NOTFOUND;
                            state_next     = S_RESULT;
                        end
                        else
                            state_next = S_SEARCH;
                    end
                    bal_pkg::FUNC_ROTATE:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = bal_pkg::ST_OK;
                        if (stat.empty)
                            state_next = S_RESULT;
                        else
                        begin
                            cmd.rem_start = 1'b1;
                            state_next    = S_MOD;
                        end
                    end
                    bal_pkg::FUNC_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = bal_pkg::ST_EMPTY;
                            state_next     = S_RESULT;
                        end
                        else
                            state_next = S_DUMP_RD;
                    end
                    default:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = bal_pkg::ST_OK;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_MOD:
            begin
                if (stat.rem_done)
                    state_next = S_COPY;
            end
            S_COPY:
            begin
                // last write drains on the same edge as the commit
                if (stat.copy_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cmd.copy = 1'b1;
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = bal_pkg::ST_OK;
                    cmd.res_hit    = 1'b1;
                    state_next     = S_RESULT;
                end
                else if (stat.scan_done && !stat.pend)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = bal_pkg::ST_NOTFOUND;
                    state_next     = S_RESULT;
                end
                else if (!stat.scan_done)
                    cmd.step = 1'b1;
            end
            S_DUMP_RD:
            begin
                cmd.step   = 1'b1;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_dump = 1'b1;
                    state_next   = stat.scan_done ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_res = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign op_stall = (state_reg != S_IDLE);

    `BAL_ASSERT_IMP(a_no_step_past_end, cmd.step && cmd.copy, !stat.copy_done, "copy overran")

endmodule

`default_nettype wire

FILE: design/bounded_array_list_engine_top.sv
// Top level of the bounded array list engine: controller, datapath, remainder unit.
// One item at a time. Insert and delete copy the list into the other bank, then swap banks;
// rotate first runs the bit-serial amount % count; search reads until a hit or the end.
// Dump outputs each element in turn; the next item is accepted the cycle after the last result
// is loaded, even if that result is still stalled. Memory is two banks of 2**clog2(CAPACITY).
// Async active-low reset empties the list; memory contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine_top #(
    parameter int CAPACITY = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // operation items
    input  wire logic               op_valid,
    output logic                    op_stall,
    input  wire bal_pkg::in_item_t  op_item,
    // result items
    output logic                    res_valid,
    input  wire logic               res_stall,
    output bal_pkg::out_item_t      res_item
);

    // Controller and datapath talk only through these two structs.
    // Insert, delete and rotate copy the list from the active bank into the
    // other bank with an index remap, then swap banks and update the count:
    //   insert at p: dst < p from dst, dst == p from the item value, else dst - 1
    //   delete at p: dst < p from dst, else dst + 1
    //   rotate by s: dst + s, wrapped at the count
    // Search scans the active bank one read per cycle; dump reads one element, then outputs it.
    bal_pkg::dp_cmd_t  cmd;
    bal_pkg::dp_stat_t stat;

    bal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_item   (op_item),
        .cmd       (cmd),
        .stat      (stat),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire

FILE: sim/bounded_array_list_engine_checker.sv
// Checker for the list engine: keeps a shadow list, predicts every result item and compares.
`timescale 1ns / 1ps

module bounded_array_list_engine_checker
    import bal_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  logic      op_stall,
    input  in_item_t  op_item,
    input  logic      res_valid,
    input  logic      res_stall,
    input  out_item_t res_item,
    output int        mismatches,
    output int        outstanding
);

    // shadow of the list contents; entries at or above shadow_len are never read
    logic signed [31:0] shadow_words [CAPACITY];
    int                 shadow_len;
    out_item_t          pending_list_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: list result mismatch, %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_result(input logic [2:0] st, input int idx,
                                         input logic signed [31:0] dat, input logic fin);
        out_item_t r;
        r.status = st;
        r.index  = idx[2:0];
        r.data   = dat;
        r.count  = shadow_len[3:0];
        r.last   = fin;
        pending_list_results.push_back(r);
    endfunction

    function automatic logic [2:0] insert_word(input int pos, input logic signed [31:0] v);
        if (shadow_len >= CAPACITY)
            return ST_FULL;
        if (pos > shadow_len)
            return ST_BADPOS;
        for (int i = shadow_len; i > pos; i--)
            shadow_words[i] = shadow_words[i - 1];
        shadow_words[pos] = v;
        shadow_len++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] remove_word(input int pos);
        if (shadow_len == 0)
            return ST_EMPTY;
        if (pos >= shadow_len)
            return ST_BADPOS;
        for (int i = pos; i + 1 < shadow_len; i++)
            shadow_words[i] = shadow_words[i + 1];
        shadow_len--;
        return ST_OK;
    endfunction

    function automatic void rotate_words(input logic [15:0] amt);
        logic signed [31:0] tmp [CAPACITY];
        int                 shift;
        int                 j;
        if (shadow_len == 0)
            return;
        shift = int'(amt) % shadow_len;
        for (int i = 0; i < shadow_len; i++)
        begin
            j = i + shift;
            if (j >= shadow_len)
                j -= shadow_len;
            tmp[i] = shadow_words[j];
        end
        for (int i = 0; i < shadow_len; i++)
            shadow_words[i] = tmp[i];
    endfunction

    // apply one operation to the shadow list and queue the results it must produce
    function automatic void apply_list_op(input in_item_t op);
        logic [2:0] st;
        int         hit_idx;
        logic       found;
        st      = ST_OK;
        hit_idx = 0;
        found   = 1'b0;
        case (op.func)
            FUNC_INS_FRONT: st = insert_word(0, op.value);
            FUNC_INS_BACK:  st = insert_word(shadow_len, op.value);
            FUNC_INS_AT:    st = insert_word(int'(op.position), op.value);
            FUNC_DEL_FRONT: st = remove_word(0);
            FUNC_DEL_BACK:  st = (shadow_len == 0) ? ST_EMPTY : remove_word(shadow_len - 1);
            FUNC_DEL_AT:    st = remove_word(int'(op.position));
            FUNC_SEARCH:
            begin
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (!found && shadow_words[i] == op.value)
                    begin
                        found   = 1'b1;
                        hit_idx = i;
                    end
                end
                st = found ? ST_OK : ST_NOTFOUND;
            end
            FUNC_ROTATE:    rotate_words(op.amount);
            FUNC_DUMP:
            begin
                if (shadow_len == 0)
                    queue_result(ST_EMPTY, 0, '0, 1'b1);
                for (int i = 0; i < shadow_len; i++)
                    queue_result(ST_OK, i, shadow_words[i], i + 1 == shadow_len);
                return;
            end
            default: ;  // unknown codes leave the list alone
        endcase
        queue_result(st, hit_idx, '0, 1'b1);
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_list_results.size() == 0)
        begin
            report_mismatch("result with no item pending", 32'(got), '0);
            return;
        end
        want = pending_list_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.index !== want.index)
            report_mismatch("index", 32'(got.index), 32'(want.index));
        if (got.data !== want.data)
            report_mismatch("data", got.data, want.data);
        if (got.count !== want.count)
            report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // results are retired before the new item is applied: no item answers in its own cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            mismatches = 0;
            pending_list_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_item);
            if (op_valid && !op_stall)
                apply_list_op(op_item);
            outstanding <= pending_list_results.size();
        end
    end

endmodule

FILE: sim/bounded_array_list_engine_top_tb.sv
// Testbench top for the list engine: clock, reset, item stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module bounded_array_list_engine_top_tb;

    import bal_pkg::*;

    localparam int LIST_CAPACITY = 8;
    localparam int LONG_HOLD     = 300;      // receiver hold-off, long enough to back up the input
    localparam int TAIL_CYCLES   = 60;       // watch for stray results after the last one
    localparam int CYCLE_LIMIT   = 400000;   // several times the slowest legal run

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      op_valid   = 1'b0;
    logic      op_stall;
    in_item_t  op_item    = '0;
    logic      res_valid;
    logic      res_stall  = 1'b0;
    out_item_t res_item;

    int        mismatches;
    int        outstanding;
    int        idle_pct      = 0;   // chance of an idle burst after each item / stall cycle
    int        hold_requests = 0;   // bumped to ask the receiver for one long hold-off
    int        cycle_count   = 0;

    bounded_array_list_engine_top #(
        .CAPACITY (LIST_CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    bounded_array_list_engine_checker #(
        .CAPACITY (LIST_CAPACITY)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_stall    (op_stall),
        .op_item     (op_item),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case results never drain
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t mk_op(input logic [3:0] func, input logic signed [31:0] value,
                                       input logic [3:0] position, input logic [15:0] amount);
        in_item_t it;
        it.func     = func;
        it.value    = value;
        it.position = position;
        it.amount   = amount;
        return it;
    endfunction

    // values come mostly from a small pool so that searches hit often
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 13))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            4:       return 32'sh0000_0001;
            5:       return 32'sh5555_5555;
            6:       return 32'shAAAA_AAAA;
            7:       return 32'sh0000_0064;
            8:       return -32'sd100;
            9:       return 32'sh0000_0007;
            default: return $urandom;
        endcase
    endfunction

    // ins_w sets the share of inserts out of 100; deletes take the rest of the first 60
    function automatic in_item_t random_op(input int ins_w);
        logic [3:0]  func;
        logic [3:0]  position;
        logic [15:0] amount;
        int          r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            func = FUNC_INS_FRONT + 4'($urandom_range(0, 2));
        else if (r < 60)
            func = FUNC_DEL_FRONT + 4'($urandom_range(0, 2));
        else if (r < 75)
            func = FUNC_SEARCH;
        else if (r < 85)
            func = FUNC_ROTATE;
        else if (r < 93)
            func = FUNC_DUMP;
        else
            func = FUNC_DUMP + 4'($urandom_range(1, 7));   // codes with no operation
        position = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                : 4'($urandom_range(0, 15));
        amount   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        return mk_op(func, pick_value(), position, amount);
    endfunction

    // offer one item, hold it until accepted, then maybe go idle for a burst
    task automatic send_op(input in_item_t it);
        op_item  <= it;
        op_valid <= 1'b1;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int n, input int ins_w);
        for (int i = 0; i < n; i++)
            send_op(random_op(ins_w));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        op_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list cases first
        idle_pct <= 20;
        send_op(mk_op(FUNC_DUMP,      '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_DEL_FRONT, '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_DEL_BACK,  '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_DEL_AT,    '0, 4'd15, 16'd0));   // empty wins over bad position
        send_op(mk_op(FUNC_SEARCH,    '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_ROTATE,    '0, 4'd0, 16'd5));
        send_op(mk_op(FUNC_INS_AT,    32'sd9, 4'd1, 16'd0)); // bad position on empty list
        // fill to capacity through every insert flavor
        send_op(mk_op(FUNC_INS_FRONT, 32'sh8000_0000, 4'd0, 16'd0));
        send_op(mk_op(FUNC_INS_BACK,  32'sh7FFF_FFFF, 4'd0, 16'd0));
        send_op(mk_op(FUNC_INS_AT,    32'sd0, 4'd1, 16'd0));
        send_op(mk_op(FUNC_INS_AT,    32'sd3, 4'd4, 16'd0)); // one past the end: bad
        send_op(mk_op(FUNC_INS_AT,    -32'sd1, 4'd3, 16'd0)); // equal to count: append
        send_op(mk_op(FUNC_INS_AT,    32'sd1, 4'd2, 16'd0));
        send_op(mk_op(FUNC_INS_FRONT, 32'shAAAA_AAAA, 4'd0, 16'd0));
        send_op(mk_op(FUNC_INS_BACK,  32'sh5555_5555, 4'd0, 16'd0));
        send_op(mk_op(FUNC_INS_BACK,  32'sd7, 4'd0, 16'd0));
        // full list: full wins over bad position
        send_op(mk_op(FUNC_INS_FRONT, 32'sd11, 4'd0, 16'd0));
        send_op(mk_op(FUNC_INS_AT,    32'sd12, 4'd15, 16'd0));
        send_op(mk_op(FUNC_DUMP,      '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_SEARCH,    32'sh7FFF_FFFF, 4'd0, 16'd0));
        send_op(mk_op(FUNC_SEARCH,    32'sd12345, 4'd0, 16'd0));
        send_op(mk_op(FUNC_ROTATE,    '0, 4'd0, 16'hFFFF));
        send_op(mk_op(FUNC_DEL_AT,    '0, 4'd15, 16'd0));
        send_op(mk_op(FUNC_DEL_AT,    '0, 4'd7, 16'd0));
        send_op(mk_op(FUNC_DEL_FRONT, '0, 4'd0, 16'd0));
        send_op(mk_op(FUNC_DEL_BACK,  '0, 4'd0, 16'd0));
        send_op(mk_op(4'hF,           32'shFFFF_FFFF, 4'hF, 16'hFFFF)); // no such operation

        // random, insert-leaning with heavy idling on both sides
        idle_pct <= 30;
        run_random(80, 40);

        // receiver holds off while the sender keeps offering, so the input backs up
        idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        run_random(20, 30);

        // sender pause until the list engine has nothing left to return
        drain_results();

        // delete-leaning with light idling
        idle_pct <= 10;
        run_random(90, 20);

        // balanced, no idling at all for the last part
        idle_pct <= 0;
        run_random(110, 32);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bal_pkg.sv
design/bal_rem.sv
design/bal_dp.sv
design/bal_ctrl.sv
design/bounded_array_list_engine_top.sv
sim/bounded_array_list_engine_checker.sv
sim/bounded_array_list_engine_top_tb.sv
